FILE: rtl/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
package mexp_pkg;

   // Default field widths
   localparam int EXP_BITS_DEF = 32;
   localparam int MOD_BITS_DEF = 30;

   // Modulus register value after reset
   localparam logic [31:0] MODULUS_RESET = 32'd998244353;

   // Register port geometry
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Byte address of the modulus register
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_MODULUS = 3'd0;

endpackage

FILE: rtl/mexp_if.sv
// Request and response channel interfaces of the modular exponentiation block.
interface mexp_req_if #(
   parameter int MOD_BITS = 30,
   parameter int EXP_BITS = 32
);
   logic                valid;
   logic                ready;
   logic [MOD_BITS-1:0] base_value;
   logic [EXP_BITS-1:0] exponent;

   modport source (output valid, output base_value, output exponent, input ready);
   modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_rsp_if #(
   parameter int MOD_BITS = 30
);
   logic                valid;
   logic                ready;
   logic [MOD_BITS-1:0] power_mod;

   modport source (output valid, output power_mod, input ready);
   modport sink   (input valid, input power_mod, output ready);
endinterface

FILE: rtl/mexp_csr.sv
// Register port holding the modulus.
module mexp_csr #(
   parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mexp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [mexp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [mexp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready,
   output logic [MOD_BITS-1:0]                modulus
);
   import mexp_pkg::*;

   logic [MOD_BITS-1:0] modulus_ff;
   logic [MOD_BITS-1:0] modulus_in;
   logic                hit;

   // Decode the register word, ignoring byte offset bits
   assign hit = (paddr[CSR_ADDR_BITS-1:2] == ADDR_MODULUS[CSR_ADDR_BITS-1:2]);

   // Take a write in the access phase
   always_comb begin
      modulus_in = modulus_ff;
      if (psel && penable && pwrite && hit) begin
         modulus_in = pwdata[MOD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[MOD_BITS-1:0];
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // Read back the modulus, zero elsewhere
   assign prdata  = hit ? CSR_DATA_BITS'(modulus_ff) : '0;
   assign pready  = 1'b1;
   assign modulus = modulus_ff;

endmodule

FILE: rtl/mexp_mulmod.sv
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
module mexp_mulmod #(
   parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] op_a,      // must be below the modulus
   input  logic [MOD_BITS-1:0] op_b,      // any value
   input  logic [MOD_BITS-1:0] modulus,
   output logic                done,
   output logic [MOD_BITS-1:0] product
);
   import mexp_pkg::*;

   localparam int W     = MOD_BITS + 1;
   localparam int CNT_W = $clog2(MOD_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] mcand_ff, mcand_in;
   logic [MOD_BITS-1:0] mplr_ff, mplr_in;

   logic [W-1:0] mod_ext;
   logic [W-1:0] dbl;
   logic [W-1:0] dbl_red;
   logic [W-1:0] sum;
   logic [W-1:0] sum_red;

   // Double, reduce, add the multiplicand if the bit is set, reduce again
   always_comb begin
      mod_ext = W'(modulus);
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
      sum     = dbl_red + (mplr_ff[MOD_BITS-1] ? W'(mcand_ff) : '0);
      sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
   end

   // Sequence the steps
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(MOD_BITS - 1);
         acc_in   = '0;
         mcand_in = op_a;
         mplr_in  = op_b;
      end else if (busy_ff) begin
         acc_in  = sum_red[MOD_BITS-1:0];
         mplr_in = {mplr_ff[MOD_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/mexp_seq.sv
// Square-and-multiply sequencer driving the shared modular multiplier.
module mexp_seq #(
   parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF,
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   mexp_req_if.sink            req_chan,
   mexp_rsp_if.source          rsp_chan,
   input  logic [MOD_BITS-1:0] modulus,
   output logic                mul_start,
   output logic [MOD_BITS-1:0] mul_a,
   output logic [MOD_BITS-1:0] mul_b,
   input  logic                mul_done,
   input  logic [MOD_BITS-1:0] mul_product
);
   import mexp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SQR    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MOD_BITS-1:0] power_ff, power_in;
   logic [MOD_BITS-1:0] base_ff, base_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [EXP_BITS-1:0] exp_next;
   logic                req_take;
   logic                rsp_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign exp_next       = exp_ff >> 1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      power_in     = power_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      mul_start    = 1'b0;
      mul_a        = acc_ff;
      mul_b        = base_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               base_in = req_chan.base_value;
               exp_in  = req_chan.exponent;
               if (modulus < MOD_BITS'(2)) begin
                  // Every value is zero modulo zero or one
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  // Reduce the base as one times the base
                  acc_in    = MOD_BITS'(1);
                  mul_start = 1'b1;
                  mul_a     = MOD_BITS'(1);
                  mul_b     = req_chan.base_value;
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in  = mul_product;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            // Visit the lowest remaining exponent bit
            if (exp_ff == '0) begin
               state_in = ST_FINISH;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end else begin
               mul_start = 1'b1;
               mul_a     = base_ff;
               state_in  = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (exp_next == '0) begin
                  exp_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = base_ff;
                  state_in  = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               base_in  = mul_product;
               exp_in   = exp_next;
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (rsp_free) begin
               power_in     = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      power_ff <= power_in;
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      exp_ff   <= exp_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.power_mod = power_ff;

endmodule

FILE: rtl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block.
//
//   port group   dir    handshake            payload
//   req_chan     in     valid / ready        base_value, exponent
//   rsp_chan     out    valid / ready        power_mod
//   apb (p*)     in     psel+penable+pwrite  modulus at byte address 0
//
// Each request first reduces the base on the multiplier. Each exponent bit up to
// the highest set one then takes a multiply and a square when set and a square
// when clear, the highest set bit only a multiply (no square follows). The
// response register is then loaded. The single bit-serial multiplier runs each step.
// Synchronous reset clears the sequencer and response valid, and loads the
// modulus with 998244353. A stalled response holds in its output register
// while the next request is accepted and computed.
module modular_exponentiation_top #(
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
   parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   mexp_req_if.sink                           req_chan,
   mexp_rsp_if.source                         rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mexp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [mexp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [mexp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import mexp_pkg::*;

   logic [MOD_BITS-1:0] modulus;
   logic                mul_start;
   logic [MOD_BITS-1:0] mul_a;
   logic [MOD_BITS-1:0] mul_b;
   logic                mul_done;
   logic [MOD_BITS-1:0] mul_product;

   mexp_csr #(.MOD_BITS(MOD_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .modulus (modulus)
   );

   mexp_mulmod #(.MOD_BITS(MOD_BITS)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus),
      .done    (mul_done),
      .product (mul_product)
   );

   mexp_seq #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .modulus     (modulus),
      .mul_start   (mul_start),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

endmodule

FILE: rtl/mexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top.
module mexp_checker #(
   parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [MOD_BITS-1:0]                power_mod,
   input logic                               psel,
   input logic                               penable,
   input logic                               pwrite,
   input logic [mexp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input logic [mexp_pkg::CSR_DATA_BITS-1:0] pwdata
);
   import mexp_pkg::*;

   logic [MOD_BITS-1:0] shadow_ff;
   logic [MOD_BITS-1:0] shadow_in;

   // Track the modulus from the write port
   always_comb begin
      shadow_in = shadow_ff;
      if (psel && penable && pwrite &&
          (paddr[CSR_ADDR_BITS-1:2] == ADDR_MODULUS[CSR_ADDR_BITS-1:2])) begin
         shadow_in = pwdata[MOD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_ff <= MODULUS_RESET[MOD_BITS-1:0];
      end else begin
         shadow_ff <= shadow_in;
      end
   end

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(power_mod))
      else $error("response changed while stalled");

   // The block is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // Results are fully reduced
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (shadow_ff >= MOD_BITS'(2)) |-> power_mod < shadow_ff)
      else $error("result not below modulus");

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind modular_exponentiation_top mexp_checker #(.MOD_BITS(MOD_BITS)) u_mexp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .power_mod (rsp_chan.power_mod),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata)
);
